// ===== src/fcw_pkg.sv =====
// fcw_pkg: command and status codes, link-word marks and the job record
// passed from the front end to the table engine. No dependencies.
`timescale 1ns / 1ps

package fcw_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_WALK  = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;

    localparam logic [2:0] ST_CONT  = 3'd0;
    localparam logic [2:0] ST_EOF   = 3'd1;
    localparam logic [2:0] ST_LOST  = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;

    localparam logic [6:0] EOF_MARK  = 7'd99;
    localparam logic [6:0] FREE_MARK = 7'd0;

    // job queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_WALK  = 2'd1,
        OP_COUNT = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] entry_index;
        logic [6:0] entry_value;
        logic [6:0] start_sector;
    } t_job;

endpackage

// ===== src/fcw_if.sv =====
// fcw_if: valid/ready channel interfaces for command requests and results.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface fcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] entry_index;
    logic [6:0] entry_value;
    logic [6:0] start_sector;

    modport source (output valid, command, entry_index, entry_value, start_sector,
                    input ready);
    modport sink   (input valid, command, entry_index, entry_value, start_sector,
                    output ready);
endinterface

interface fcw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] sector;
    logic [5:0] free_count;
    logic [2:0] status;
    logic       last;

    modport source (output valid, sector, free_count, status, last, input ready);
    modport sink   (input valid, sector, free_count, status, last, output ready);
endinterface

// ===== src/fcw_front.sv =====
// fcw_front: takes requests, decodes the command and queues jobs for the engine.
// Depends on fcw_pkg and fcw_in_if.
`timescale 1ns / 1ps

module fcw_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcw_in_if.sink       i_req,
    output logic         o_job_valid,
    output fcw_pkg::t_job o_job,
    input  logic         i_job_ready
);
    import fcw_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PW:0]   r_fill, n_fill;

    logic accept;
    logic push;
    logic pop;
    t_job job_in;

    assign i_req.ready = (r_fill != QUEUE_PW'(0) + (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign accept      = i_req.valid && i_req.ready;

    // unused command code is accepted and dropped here
    always_comb begin
        push          = 1'b0;
        job_in.op     = OP_WRITE;
        unique case (i_req.command)
            CMD_WRITE: begin
                push      = accept;
                job_in.op = OP_WRITE;
            end
            CMD_WALK: begin
                push      = accept;
                job_in.op = OP_WALK;
            end
            CMD_COUNT: begin
                push      = accept;
                job_in.op = OP_COUNT;
            end
            default: begin
                push      = 1'b0;
                job_in.op = OP_WRITE;
            end
        endcase
        job_in.entry_index  = i_req.entry_index;
        job_in.entry_value  = i_req.entry_value;
        job_in.start_sector = i_req.start_sector;
    end

    assign o_job_valid = (r_fill != '0);
    assign o_job       = r_slot[r_rd_ptr];
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill + (QUEUE_PW+1)'(push) - (QUEUE_PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= job_in;
        end
    end

endmodule

// ===== src/fcw_back.sv =====
// fcw_back: link table, free counter, chain-walk sequencer and result register.
// Depends on fcw_pkg, fcw_out_if.
`timescale 1ns / 1ps

module fcw_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  fcw_pkg::t_job i_job,
    output logic          o_job_ready,
    fcw_out_if.source     o_rsp
);
    import fcw_pkg::*;

    // only entries below 64 can ever be written; higher ones stay free
    localparam int DEPTH = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLIM  = (TABLE_ENTRIES - 1 < 63) ? TABLE_ENTRIES - 1 : 63;
    localparam int WLIM  = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;
    localparam int NW    = $clog2(WLIM);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_LINK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [6:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_used;       // entry holds a nonzero link word
    logic [6:0]       r_rd_data;
    logic             r_rd_used;

    logic [5:0]    r_free_total, n_free_total;
    logic [6:0]    r_cur, n_cur;
    logic [NW-1:0] r_n, n_n;

    logic       r_out_valid, n_out_valid;
    logic [6:0] r_out_sector, n_out_sector;
    logic [5:0] r_out_free, n_out_free;
    logic [2:0] r_out_status, n_out_status;
    logic       r_out_last, n_out_last;

    logic          out_free;
    logic          do_write;
    logic          wr_in_range;
    logic          wr_counted;
    logic [AW-1:0] wr_addr;
    logic          was_free;
    logic          now_free;
    logic          do_read;
    logic          cur_in_tab;
    logic [6:0]    link;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign wr_in_range = int'(i_job.entry_index) < TABLE_ENTRIES;
    assign wr_counted  = (i_job.entry_index != 6'd0) && (int'(i_job.entry_index) <= CLIM);
    assign wr_addr     = i_job.entry_index[AW-1:0];
    assign was_free    = !r_used[wr_addr];
    assign now_free    = (i_job.entry_value == FREE_MARK);
    assign cur_in_tab  = int'(r_cur) < DEPTH;
    assign link        = r_rd_used ? r_rd_data : FREE_MARK;

    always_comb begin
        n_state      = r_state;
        n_free_total = r_free_total;
        n_cur        = r_cur;
        n_n          = r_n;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_sector = r_out_sector;
        n_out_free   = r_out_free;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_job_ready  = 1'b0;
        do_write     = 1'b0;
        do_read      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.op)
                        OP_WRITE: begin
                            o_job_ready = 1'b1;
                            do_write    = wr_in_range;
                            if (wr_in_range && wr_counted) begin
                                if (was_free && !now_free) begin
                                    n_free_total = r_free_total - 6'd1;
                                end else if (!was_free && now_free) begin
                                    n_free_total = r_free_total + 6'd1;
                                end
                            end
                        end
                        OP_WALK: begin
                            o_job_ready = 1'b1;
                            n_cur       = i_job.start_sector;
                            n_n         = '0;
                            n_state     = S_CHECK;
                        end
                        OP_COUNT: begin
                            o_job_ready = out_free;
                            if (out_free) begin
                                n_out_valid  = 1'b1;
                                n_out_sector = 7'd0;
                                n_out_free   = r_free_total;
                                n_out_status = ST_COUNT;
                                n_out_last   = 1'b1;
                            end
                        end
                        default: begin
                            o_job_ready = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // sector itself ends the walk before any table read
                priority if (r_cur == EOF_MARK || r_cur == FREE_MARK ||
                             int'(r_cur) >= TABLE_ENTRIES) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_sector = r_cur;
                        n_out_free   = 6'd0;
                        n_out_last   = 1'b1;
                        priority if (r_cur == EOF_MARK) begin
                            n_out_status = ST_EOF;
                        end else if (r_cur == FREE_MARK) begin
                            n_out_status = ST_LOST;
                        end else begin
                            n_out_status = ST_BAD;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    do_read = 1'b1;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sector = r_cur;
                    n_out_free   = 6'd0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                    priority if (link == EOF_MARK) begin
                        n_out_status = ST_EOF;
                    end else if (link == FREE_MARK) begin
                        n_out_status = ST_LOST;
                    end else if (int'(r_n) + 1 >= WLIM) begin
                        // loop guard: chain ran past the step limit
                        n_out_status = ST_BAD;
                    end else begin
                        n_out_status = ST_CONT;
                        n_out_last   = 1'b0;
                        n_cur        = link;
                        n_n          = r_n + 1'b1;
                        n_state      = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_free_total <= 6'(CLIM);
            r_cur        <= '0;
            r_n          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_total <= n_free_total;
            r_cur        <= n_cur;
            r_n          <= n_n;
            r_out_valid  <= n_out_valid;
            if (do_write) begin
                r_used[wr_addr] <= !now_free;
            end
        end
    end

    // table storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_addr] <= i_job.entry_value;
        end
        if (do_read) begin
            r_rd_data <= r_mem[r_cur[AW-1:0]];
            r_rd_used <= cur_in_tab && r_used[r_cur[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sector <= n_out_sector;
        r_out_free   <= n_out_free;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.sector     = r_out_sector;
    assign o_rsp.free_count = r_out_free;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.last       = r_out_last;

endmodule

// ===== src/fat_chain_walker.sv =====
// fat_chain_walker: top level tying the request front end to the table engine.
// Depends on fcw_pkg, fcw_if, fcw_front, fcw_back.
//
// Usage:
//   i_req carries write, walk and count requests (valid/ready). o_rsp carries
//   results (valid/ready); the final result of a request has last set.
//   A write gives no result. A count gives one result, registered in the
//   cycle after the engine takes it. A walk gives one result per visited
//   sector; each sector takes a table read, then a decision on the
//   registered link word, and the dependent table read sets the walk's pace.
//   Requests pass a two-deep job queue, so the front keeps accepting while
//   the engine works; a request reaches the engine in the cycle after accept
//   at the earliest.
//   Reset marks every table entry free at once (per-entry flags) and sets the
//   free total to the table's countable size; no clearing pass is needed.
//   When o_rsp stalls, the result register holds and the walk pauses; the
//   queue fills and then i_req.ready drops.
`timescale 1ns / 1ps

module fat_chain_walker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcw_in_if.sink    i_req,
    fcw_out_if.source o_rsp
);
    import fcw_pkg::*;

    logic job_valid;
    logic job_ready;
    t_job job;

    fcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    fcw_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_rsp       (o_rsp)
    );

endmodule
